[design/uf2bfs_pkg.sv]
package uf2bfs_pkg;

    // Header words that mark a valid block
    localparam logic [31:0] MAGIC_FIRST  = 32'h0A32_4655;
    localparam logic [31:0] MAGIC_SECOND = 32'h9E5D_5157;
    localparam logic [31:0] MAGIC_FINAL  = 32'h0AB1_6F30;

    // Family that keeps the slow serial rate
    localparam logic [31:0] SLOW_FAMILY = 32'h7EAB_61ED;

    // Item kinds carried on the input tuser
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_FIRST_DATA_SECTOR = 1'b0;
    localparam logic CFG_RESET_HOLD_TICKS  = 1'b1;

    // Configuration reset values
    localparam logic [15:0] FIRST_DATA_SECTOR_RST = 16'd35;
    localparam logic [23:0] RESET_HOLD_TICKS_RST  = 24'd100000;

    // Result actions
    typedef enum logic [2:0] {
        ACT_IGNORED = 3'd0,
        ACT_BUSY    = 3'd1,
        ACT_SEQ     = 3'd2,
        ACT_START   = 3'd3,
        ACT_WRITE   = 3'd4,
        ACT_FINISH  = 3'd5,
        ACT_ABORT   = 3'd6
    } action_t;

    // One input item
    typedef struct packed {
        logic        op;
        logic [15:0] lba;
        logic [31:0] first_magic;
        logic [31:0] second_magic;
        logic [31:0] final_magic;
        logic [31:0] target_addr;
        logic [31:0] payload_bytes;
        logic [31:0] block_number;
        logic [31:0] total_blocks;
        logic [31:0] family_id;
    } item_t;

    // One result item
    typedef struct packed {
        action_t     action;
        logic [31:0] flash_addr;
        logic [31:0] erase_length;
        logic [31:0] write_length;
        logic        fast_baud;
        logic        reset_active;
    } result_t;

endpackage

[design/uf2bfs_in_reg.sv]
module uf2bfs_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  uf2bfs_pkg::item_t   in_item,
    input  logic                advance,
    output logic                item_valid,
    output uf2bfs_pkg::item_t   item
);

    logic              valid_reg;
    logic              valid_next;
    uf2bfs_pkg::item_t item_reg;

    // The stage takes a new transfer when empty or when its item moves on
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload loads on every accepted transfer
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[design/uf2bfs_decide.sv]
module uf2bfs_decide
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_sel,
    input  logic [23:0]           cfg_value,
    input  logic                  commit,
    input  uf2bfs_pkg::item_t     item,
    output uf2bfs_pkg::result_t   result
);

    // Configuration registers
    logic [15:0] first_sector_reg;
    logic [23:0] hold_ticks_reg;

    // Sequencer state; last_reg holds -1 as all ones
    logic [32:0] last_reg;
    logic [32:0] last_next;
    logic [31:0] chunk_reg;
    logic [31:0] chunk_next;
    logic [31:0] blocks_reg;
    logic [31:0] blocks_next;
    logic [23:0] hold_reg;
    logic [23:0] hold_next;
    logic        halted_reg;
    logic        halted_next;

    logic        header_ok;
    logic        in_sequence;
    logic        is_start;
    logic        is_last;
    logic        oversize;
    logic [31:0] product;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sector_reg <= uf2bfs_pkg::FIRST_DATA_SECTOR_RST;
            hold_ticks_reg   <= uf2bfs_pkg::RESET_HOLD_TICKS_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_sel == uf2bfs_pkg::CFG_FIRST_DATA_SECTOR)
            begin
                first_sector_reg <= cfg_value[15:0];
            end
            else
            begin
                hold_ticks_reg <= cfg_value;
            end
        end
    end

    // Header checks and the erase length
    assign header_ok   = (item.lba >= first_sector_reg)
                         && (item.first_magic == uf2bfs_pkg::MAGIC_FIRST)
                         && (item.second_magic == uf2bfs_pkg::MAGIC_SECOND)
                         && (item.final_magic == uf2bfs_pkg::MAGIC_FINAL);
    assign in_sequence = ((last_reg + 33'd1) == {1'b0, item.block_number});
    assign is_start    = (item.block_number == 32'd0);
    assign is_last     = (item.block_number == (item.total_blocks - 32'd1));
    assign oversize    = (item.payload_bytes > chunk_reg)
                         || (item.total_blocks != blocks_reg);
    assign product     = item.total_blocks * item.payload_bytes;

    // Decision for the item in the input register
    always_comb
    begin
        last_next           = last_reg;
        chunk_next          = chunk_reg;
        blocks_next         = blocks_reg;
        hold_next           = hold_reg;
        halted_next         = halted_reg;
        result.action       = uf2bfs_pkg::ACT_IGNORED;
        result.flash_addr   = 32'd0;
        result.erase_length = 32'd0;
        result.write_length = 32'd0;
        result.fast_baud    = 1'b0;

        if (item.op == uf2bfs_pkg::OP_TICK)
        begin
            if (hold_reg != 24'd0)
            begin
                hold_next = hold_reg - 24'd1;
            end
        end
        else if (halted_reg)
        begin
            result.action = uf2bfs_pkg::ACT_ABORT;
        end
        else if (hold_reg != 24'd0)
        begin
            result.action = uf2bfs_pkg::ACT_BUSY;
        end
        else if (!header_ok)
        begin
            result.action = uf2bfs_pkg::ACT_IGNORED;
        end
        else if (!in_sequence)
        begin
            result.action = uf2bfs_pkg::ACT_SEQ;
        end
        else if (!is_start && oversize)
        begin
            result.action = uf2bfs_pkg::ACT_ABORT;
            halted_next   = 1'b1;
        end
        else
        begin
            result.flash_addr   = item.target_addr;
            result.write_length = item.payload_bytes;
            result.fast_baud    = (item.family_id != uf2bfs_pkg::SLOW_FAMILY);
            last_next           = {1'b0, item.block_number};
            result.action       = is_start ? uf2bfs_pkg::ACT_START
                                           : uf2bfs_pkg::ACT_WRITE;
            if (is_start)
            begin
                chunk_next          = item.payload_bytes;
                blocks_next         = item.total_blocks;
                result.erase_length = product;
            end
            if (is_last)
            begin
                // A hold setting of zero still holds for one tick.
                hold_next = (hold_ticks_reg == 24'd0) ? 24'd1 : hold_ticks_reg;
                last_next = '1;
                if (!is_start)
                begin
                    result.action = uf2bfs_pkg::ACT_FINISH;
                end
            end
        end

        result.reset_active = (hold_next != 24'd0);
    end

    // State moves only when the item passes into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= '1;
            chunk_reg  <= 32'd0;
            blocks_reg <= 32'd0;
            hold_reg   <= 24'd0;
            halted_reg <= 1'b0;
        end
        else if (commit)
        begin
            last_reg   <= last_next;
            chunk_reg  <= chunk_next;
            blocks_reg <= blocks_next;
            hold_reg   <= hold_next;
            halted_reg <= halted_next;
        end
    end

endmodule

[design/uf2bfs_out_reg.sv]
module uf2bfs_out_reg
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  uf2bfs_pkg::result_t   load_result,
    output logic                  free,
    output logic                  out_valid,
    input  logic                  out_ready,
    output uf2bfs_pkg::result_t   out_result
);

    logic                valid_reg;
    logic                valid_next;
    uf2bfs_pkg::result_t result_reg;

    // The register frees up when empty or when its transfer completes
    assign free       = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

[design/uf2_block_flash_sequencer.sv]
// Block flash sequencer for a drag-and-drop firmware loader.
//
// The slave stream carries ticks (tuser 0) and sector writes (tuser 1) with
// the block header fields in tdata. Each item gives exactly one result on
// the master stream: an action code in tuser and the erase and write
// command fields in tdata. Blocks must arrive in order; block 0 latches the
// chunk size and count and orders the erase, the last block starts the
// target-reset hold, which ticks then count down.
//
// The result is registered: the item waits in the input register while the
// header checks and the 32 by 32 erase-length multiply settle, and the
// result register loads once it is free. One item is taken every cycle
// while results are consumed.
//
// When the receiver stalls the result register holds, and the input
// register still takes one more item; after that s_tready drops. Reset
// empties both registers, restores the configuration defaults and rewinds
// the sequence with no hold active. The configuration channel is always
// ready and is written by the user only while the block is idle (unchecked).
module uf2_block_flash_sequencer
(
    input  logic          clk,
    input  logic          rst_n,

    input  logic          s_tvalid,
    output logic          s_tready,
    // lba, first_magic, second_magic, final_magic, target_addr,
    // payload_bytes, block_number, total_blocks, family_id
    input  logic [271:0]  s_tdata,
    // op
    input  logic          s_tuser,

    output logic          m_tvalid,
    input  logic          m_tready,
    // flash_addr, erase_length, write_length, fast_baud, reset_active, zero pad
    output logic [103:0]  m_tdata,
    // action
    output logic [2:0]    m_tuser,

    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [23:0]   cfg_data
);

    uf2bfs_pkg::item_t   s_item;
    uf2bfs_pkg::item_t   item;
    uf2bfs_pkg::result_t result;
    uf2bfs_pkg::result_t m_result;
    logic                item_valid;
    logic                out_free;
    logic                advance;

    // Unpack the input transfer
    assign s_item.op            = s_tuser;
    assign s_item.lba           = s_tdata[15:0];
    assign s_item.first_magic   = s_tdata[47:16];
    assign s_item.second_magic  = s_tdata[79:48];
    assign s_item.final_magic   = s_tdata[111:80];
    assign s_item.target_addr   = s_tdata[143:112];
    assign s_item.payload_bytes = s_tdata[175:144];
    assign s_item.block_number  = s_tdata[207:176];
    assign s_item.total_blocks  = s_tdata[239:208];
    assign s_item.family_id     = s_tdata[271:240];

    assign cfg_ready = 1'b1;
    assign advance   = item_valid && out_free;

    uf2bfs_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    uf2bfs_decide u_decide
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_sel   (cfg_index),
        .cfg_value (cfg_data),
        .commit    (advance),
        .item      (item),
        .result    (result)
    );

    uf2bfs_out_reg u_out_reg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .load_result (result),
        .free        (out_free),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (m_result)
    );

    // Pack the result transfer
    assign m_tuser = m_result.action;
    assign m_tdata = {6'd0, m_result.reset_active, m_result.fast_baud,
                      m_result.write_length, m_result.erase_length,
                      m_result.flash_addr};

    // A busy answer only comes while the hold is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_result.action == uf2bfs_pkg::ACT_BUSY)
        |-> m_result.reset_active)
        else $error("busy result without an active reset hold");

    // Finishing an image always starts the hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_result.action == uf2bfs_pkg::ACT_FINISH)
        |-> m_result.reset_active)
        else $error("finish result without an active reset hold");

    // An empty input register never blocks the slave side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid |-> s_tready)
        else $error("input stalled while the input register is empty");

    // Only write actions carry a write length.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_result.action != uf2bfs_pkg::ACT_START)
        && (m_result.action != uf2bfs_pkg::ACT_WRITE)
        && (m_result.action != uf2bfs_pkg::ACT_FINISH)
        |-> (m_result.write_length == 32'd0) && !m_result.fast_baud)
        else $error("command fields set on a non-write result");

endmodule

[tb/uf2_block_flash_sequencer_tb.sv]
`timescale 1ns / 1ps

// Tracks the loader state, works out the action for every accepted item and
// compares the results of the block against those actions in order.
class flash_action_tracker;
    logic [15:0]           data_start;
    logic [23:0]           hold_reload;
    logic signed [32:0]    last_block;
    logic [31:0]           chunk_bytes;
    logic [31:0]           image_blocks;
    logic [23:0]           hold_left;
    bit                    halted;
    uf2bfs_pkg::result_t   expected_actions[$];
    int                    mismatches;

    function new();
        data_start   = uf2bfs_pkg::FIRST_DATA_SECTOR_RST;
        hold_reload  = uf2bfs_pkg::RESET_HOLD_TICKS_RST;
        last_block   = -33'sd1;
        chunk_bytes  = '0;
        image_blocks = '0;
        hold_left    = '0;
        halted       = 1'b0;
        mismatches   = 0;
    endfunction

    function void write_reg(logic index, logic [23:0] value);
        if (index == uf2bfs_pkg::CFG_FIRST_DATA_SECTOR)
            data_start = value[15:0];
        else
            hold_reload = value;
    endfunction

    function int pending();
        return expected_actions.size();
    endfunction

    // Apply one accepted item to the state and queue the action it causes.
    function void note_item(uf2bfs_pkg::item_t it);
        uf2bfs_pkg::result_t r;
        logic [31:0]         product;
        logic                begins;
        r = '0;
        r.action = uf2bfs_pkg::ACT_IGNORED;
        if (it.op == uf2bfs_pkg::OP_TICK)
        begin
            if (hold_left != 0)
                hold_left = hold_left - 24'd1;
        end
        else if (halted)
            r.action = uf2bfs_pkg::ACT_ABORT;
        else if (hold_left != 0)
            r.action = uf2bfs_pkg::ACT_BUSY;
        else if (it.lba < data_start || it.first_magic != uf2bfs_pkg::MAGIC_FIRST ||
                 it.second_magic != uf2bfs_pkg::MAGIC_SECOND ||
                 it.final_magic != uf2bfs_pkg::MAGIC_FINAL)
            r.action = uf2bfs_pkg::ACT_IGNORED;
        else if (last_block + 33'sd1 != $signed({1'b0, it.block_number}))
            r.action = uf2bfs_pkg::ACT_SEQ;
        else
        begin
            begins = (it.block_number == 32'd0);
            product = '0;
            if (begins)
            begin
                chunk_bytes  = it.payload_bytes;
                image_blocks = it.total_blocks;
                product      = it.total_blocks * it.payload_bytes;
            end
            if (it.payload_bytes > chunk_bytes || it.total_blocks != image_blocks)
            begin
                halted = 1'b1;
                r.action = uf2bfs_pkg::ACT_ABORT;
            end
            else
            begin
                last_block = $signed({1'b0, it.block_number});
                r.action = begins ? uf2bfs_pkg::ACT_START : uf2bfs_pkg::ACT_WRITE;
                if (it.block_number == it.total_blocks - 32'd1)
                begin
                    hold_left  = (hold_reload == 0) ? 24'd1 : hold_reload;
                    last_block = -33'sd1;
                    if (!begins)
                        r.action = uf2bfs_pkg::ACT_FINISH;
                end
                r.flash_addr   = it.target_addr;
                r.erase_length = product;
                r.write_length = it.payload_bytes;
                r.fast_baud    = (it.family_id != uf2bfs_pkg::SLOW_FAMILY);
            end
        end
        r.reset_active = (hold_left != 0);
        expected_actions.push_back(r);
    endfunction

    // Compare one result transfer with the oldest queued action.
    function void check_result(uf2bfs_pkg::result_t got);
        uf2bfs_pkg::result_t want;
        if (expected_actions.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with no item pending, action %0d",
                         $time, got.action);
            return;
        end
        want = expected_actions.pop_front();
        if (got.action !== want.action || got.flash_addr !== want.flash_addr ||
            got.erase_length !== want.erase_length ||
            got.write_length !== want.write_length ||
            got.fast_baud !== want.fast_baud || got.reset_active !== want.reset_active)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t: mismatch exp act %0d addr %h size %h len %h fast %b rst %b,",
                          " got act %0d addr %h size %h len %h fast %b rst %b"},
                         $time, want.action, want.flash_addr, want.erase_length,
                         want.write_length, want.fast_baud, want.reset_active,
                         got.action, got.flash_addr, got.erase_length,
                         got.write_length, got.fast_baud, got.reset_active);
        end
    endfunction
endclass

module uf2_block_flash_sequencer_tb;

    logic          clk;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [271:0]  s_tdata = '0;
    logic          s_tuser = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [103:0]  m_tdata;
    logic [2:0]    m_tuser;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic          cfg_index = 1'b0;
    logic [23:0]   cfg_data = '0;

    flash_action_tracker tracker = new();

    // Current settings as the stimulus sees them.
    logic [15:0]   cur_start = uf2bfs_pkg::FIRST_DATA_SECTOR_RST;
    logic [23:0]   cur_hold = uf2bfs_pkg::RESET_HOLD_TICKS_RST;
    int            src_idle_pct = 0;
    int            sink_stall_pct = 0;
    int            counted = 0;

    uf2_block_flash_sequencer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [271:0] pack_item(uf2bfs_pkg::item_t it);
        return {it.family_id, it.total_blocks, it.block_number, it.payload_bytes,
                it.target_addr, it.final_magic, it.second_magic, it.first_magic, it.lba};
    endfunction

    function automatic uf2bfs_pkg::item_t unpack_item(logic [271:0] d, logic op);
        uf2bfs_pkg::item_t it;
        it.op            = op;
        it.lba           = d[15:0];
        it.first_magic   = d[47:16];
        it.second_magic  = d[79:48];
        it.final_magic   = d[111:80];
        it.target_addr   = d[143:112];
        it.payload_bytes = d[175:144];
        it.block_number  = d[207:176];
        it.total_blocks  = d[239:208];
        it.family_id     = d[271:240];
        return it;
    endfunction

    function automatic uf2bfs_pkg::result_t unpack_result(logic [103:0] d, logic [2:0] act);
        uf2bfs_pkg::result_t r;
        r.action       = uf2bfs_pkg::action_t'(act);
        r.flash_addr   = d[31:0];
        r.erase_length = d[63:32];
        r.write_length = d[95:64];
        r.fast_baud    = d[96];
        r.reset_active = d[97];
        return r;
    endfunction

    function automatic uf2bfs_pkg::item_t make_block(logic [15:0] lba, logic [31:0] bno,
                                                     logic [31:0] bcnt, logic [31:0] psize,
                                                     logic [31:0] addr, logic [31:0] fam);
        uf2bfs_pkg::item_t it;
        it.op            = uf2bfs_pkg::OP_WRITE;
        it.lba           = lba;
        it.first_magic   = uf2bfs_pkg::MAGIC_FIRST;
        it.second_magic  = uf2bfs_pkg::MAGIC_SECOND;
        it.final_magic   = uf2bfs_pkg::MAGIC_FINAL;
        it.target_addr   = addr;
        it.payload_bytes = psize;
        it.block_number  = bno;
        it.total_blocks  = bcnt;
        it.family_id     = fam;
        return it;
    endfunction

    // A tick carries random content in the fields it does not use.
    function automatic uf2bfs_pkg::item_t make_tick();
        uf2bfs_pkg::item_t it;
        it = make_block(16'($urandom_range(16'hFFFF)), $urandom, $urandom, $urandom,
                        $urandom, $urandom);
        it.first_magic  = $urandom;
        it.second_magic = $urandom;
        it.final_magic  = $urandom;
        it.op           = uf2bfs_pkg::OP_TICK;
        return it;
    endfunction

    function automatic logic [31:0] pick_family();
        return ($urandom_range(3) == 0) ? uf2bfs_pkg::SLOW_FAMILY : $urandom;
    endfunction

    function automatic logic [15:0] data_lba();
        return 16'($urandom_range(16'hFFFF, cur_start));
    endfunction

    // Both transfer groups are sampled together at every edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tracker.note_item(unpack_item(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
                tracker.check_result(unpack_result(m_tdata, m_tuser));
        end
    end

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Offer one item and return at the edge of its transfer; valid stays high.
    task automatic send(input uf2bfs_pkg::item_t it, input bit counts);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= pack_item(it);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (counts)
            counted++;
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
        repeat (3) @(posedge clk);
    endtask

    // Write both registers while the block is idle.
    task automatic load_config(input logic [23:0] start_word, input logic [23:0] hold);
        cfg_valid <= 1'b1;
        cfg_index <= uf2bfs_pkg::CFG_FIRST_DATA_SECTOR;
        cfg_data  <= start_word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= uf2bfs_pkg::CFG_RESET_HOLD_TICKS;
        cfg_data  <= hold;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.write_reg(uf2bfs_pkg::CFG_FIRST_DATA_SECTOR, start_word);
        tracker.write_reg(uf2bfs_pkg::CFG_RESET_HOLD_TICKS, hold);
        cur_start = start_word[15:0];
        cur_hold  = hold;
        @(posedge clk);
    endtask

    // One stray item: a tick, a rejected write or an out-of-order block.
    task automatic send_noise(input logic [31:0] next_bno);
        uf2bfs_pkg::item_t it;
        logic [31:0]       flip;
        logic [31:0]       skip;
        flip = 32'd1 << $urandom_range(31);
        it = make_block(data_lba(), $urandom, $urandom, $urandom, $urandom, pick_family());
        case ($urandom_range(4))
            0: send(make_tick(), 1'b1);
            1:
            begin
                it.first_magic  = $urandom;
                it.second_magic = $urandom;
                it.final_magic  = $urandom;
                send(it, 1'b0);
            end
            2:
            begin
                case ($urandom_range(2))
                    0: it.first_magic = it.first_magic ^ flip;
                    1: it.second_magic = it.second_magic ^ flip;
                    default: it.final_magic = it.final_magic ^ flip;
                endcase
                send(it, 1'b0);
            end
            3:
            begin
                if (cur_start != 0)
                begin
                    it.lba = 16'($urandom_range(cur_start - 16'd1));
                    send(it, 1'b0);
                end
                else
                    send(make_tick(), 1'b1);
            end
            default:
            begin
                skip = $urandom_range(1) ? $urandom_range(1, 3) : $urandom;
                if (skip == 0)
                    skip = 32'd1;
                it.block_number = next_bno + skip;
                send(it, 1'b1);
            end
        endcase
    endtask

    // Count the reset hold down, with some writes landing while it is active.
    task automatic clear_hold();
        int hold_ticks;
        hold_ticks = (cur_hold == 24'd0) ? 1 : int'(cur_hold);
        repeat (hold_ticks)
        begin
            if ($urandom_range(4) == 0)
                send(make_block(data_lba(), $urandom_range(1) ? 32'd0 : $urandom,
                                $urandom_range(4), $urandom, $urandom, pick_family()), 1'b1);
            send(make_tick(), 1'b1);
        end
    endtask

    // A complete image in order, with stray items mixed in.
    task automatic send_image();
        int unsigned n;
        logic [31:0] chunk;
        logic [31:0] psize;
        n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 6);
        case ($urandom_range(3))
            0: chunk = 32'd512;
            1: chunk = $urandom_range(64);
            default: chunk = $urandom;
        endcase
        for (int unsigned b = 0; b < n; b++)
        begin
            while ($urandom_range(99) < 15)
                send_noise(b);
            psize = (b != 0 && $urandom_range(3) == 0) ? ($urandom & chunk) : chunk;
            send(make_block(data_lba(), b, n, psize, $urandom, pick_family()), 1'b1);
            // A repeated block is out of sequence.
            if (b + 1 < n && $urandom_range(19) == 0)
                send(make_block(data_lba(), b, n, psize, $urandom, pick_family()), 1'b1);
        end
        clear_hold();
    endtask

    task automatic random_phase(input int n_items, input int src_pct, input int sink_pct);
        int target;
        wait_results();
        load_config({8'($urandom_range(255)),
                     16'($urandom_range(1) ? $urandom_range(1000) : $urandom_range(65535))},
                    24'($urandom_range(1, 12)));
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        target = counted + n_items;
        while (counted < target)
        begin
            if ($urandom_range(99) < 75)
                send_image();
            else
                send_noise(32'd0);
            // Let the pipeline run dry now and then.
            if ($urandom_range(99) < 4)
                wait_results();
        end
    endtask

    initial
    begin
        bit by_size;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: data area from sector 35, long hold never started.
        send(make_block(16'd34, 32'd0, 32'd1, 32'd512, $urandom, $urandom), 1'b1);
        send(make_block(16'd35, 32'd3, 32'd4, 32'd512, $urandom, $urandom), 1'b1);
        // One bit flipped in the lba, the first magic word and the second magic word.
        send(uf2bfs_pkg::item_t'(make_block(16'd35, 32'd0, 32'd1, 32'd512, $urandom, $urandom)
             ^ {1'b0, 16'd0, 32'h1, 256'd0}), 1'b1);
        send(uf2bfs_pkg::item_t'(make_block(16'd35, 32'd0, 32'd1, 32'd512, $urandom, $urandom)
             ^ {1'b0, 16'd0, 32'd0, 32'h8000_0000, 224'd0}), 1'b1);
        send(uf2bfs_pkg::item_t'(make_block(16'd35, 32'd0, 32'd1, 32'd512, $urandom, $urandom)
             ^ {1'b0, 16'd0, 64'd0, 32'h0000_0100, 192'd0}), 1'b1);
        send(make_tick(), 1'b1);
        wait_results();

        // Data area from sector 0 and a hold register of zero, taken as one tick.
        load_config(24'd0, 24'd0);
        send(make_block(16'd0, 32'd0, 32'd1, 32'd512, 32'h0001_0000,
                        uf2bfs_pkg::SLOW_FAMILY), 1'b1);
        send(make_block(16'd0, 32'd0, 32'd1, 32'd512, 32'h0001_0000, $urandom), 1'b1);
        send(make_tick(), 1'b1);
        send(make_block(16'd0, 32'd0, 32'd3, 32'hFFFF_FFFF, 32'd0, $urandom), 1'b1);
        send(make_block(16'd0, 32'd1, 32'd3, 32'd0, 32'hFFFF_FFFF, 32'd0), 1'b1);
        send(make_block(16'd0, 32'd1, 32'd3, 32'd0, 32'hFFFF_FFFF, 32'd0), 1'b1);
        send(make_block(16'hFFFF, 32'd2, 32'd3, 32'hFFFF_FFFF, $urandom, 32'hFFFF_FFFF),
             1'b1);
        send(make_tick(), 1'b1);

        random_phase(125, 0, 0);
        random_phase(125, 68, 0);
        random_phase(125, 0, 68);
        random_phase(125, 30, 30);

        // Largest settings, then an image that ends in a sticky abort.
        wait_results();
        load_config({8'hA5, 16'hFFFF}, 24'hFF_FFFF);
        by_size = $urandom_range(1);
        send(make_block(16'hFFFF, 32'd0, 32'd0, 32'h8000_0000, $urandom, $urandom), 1'b1);
        send(make_block(16'hFFFF, 32'd1, 32'd0, 32'h8000_0000, $urandom, $urandom), 1'b1);
        if (by_size)
            send(make_block(16'hFFFF, 32'd2, 32'd0, 32'h8000_0001, $urandom, $urandom), 1'b1);
        else
            send(make_block(16'hFFFF, 32'd2, 32'd7, 32'd16, $urandom, $urandom), 1'b1);
        send(make_block(16'hFFFF, 32'd2, 32'd0, 32'd16, $urandom, $urandom), 1'b1);
        send(make_block(16'hFFFF, 32'd0, 32'd1, 32'd16, $urandom, $urandom), 1'b1);
        send(make_tick(), 1'b1);
        send_noise(32'd0);
        send_noise(32'd0);
        wait_results();

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
design/uf2bfs_pkg.sv
design/uf2bfs_in_reg.sv
design/uf2bfs_decide.sv
design/uf2bfs_out_reg.sv
design/uf2_block_flash_sequencer.sv
tb/uf2_block_flash_sequencer_tb.sv
